>>> design/wav_pcm_stream_deinterleaver_unit_assert.svh
// Assertion macros shared by the deinterleaver modules.
`ifndef WAV_PCM_STREAM_DEINTERLEAVER_UNIT_ASSERT_SVH
`define WAV_PCM_STREAM_DEINTERLEAVER_UNIT_ASSERT_SVH
`ifndef SYNTHESIS
`define WPD_ASSERT_ALWAYS(lbl, clk, rst_n, expr, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (expr)) else $error(msg);
`define WPD_ASSERT_IMPL(lbl, clk, rst_n, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) else $error(msg);
`else
`define WPD_ASSERT_ALWAYS(lbl, clk, rst_n, expr, msg)
`define WPD_ASSERT_IMPL(lbl, clk, rst_n, ante, cons, msg)
`endif
`endif

>>> design/wpd_pkg.sv
// Types and constants shared by the WAV PCM deinterleaver modules.
`timescale 1ns / 1ps
`default_nettype none
package wpd_pkg;

  localparam logic [5:0] HDR_LEN      = 6'd44;
  localparam logic [5:0] HDR_LAST     = 6'd43;
  localparam logic [5:0] OFF_CHAN_LO  = 6'd22;
  localparam logic [5:0] OFF_CHAN_HI  = 6'd23;
  localparam logic [5:0] OFF_RATE_B0  = 6'd24;
  localparam logic [5:0] OFF_RATE_B1  = 6'd25;
  localparam logic [5:0] OFF_RATE_B2  = 6'd26;
  localparam logic [5:0] OFF_RATE_B3  = 6'd27;
  localparam logic [5:0] OFF_BITS_LO  = 6'd34;
  localparam logic [5:0] OFF_BITS_HI  = 6'd35;

  localparam logic [12:0] BPS_ONE  = 13'd1;
  localparam logic [12:0] BPS_TWO  = 13'd2;
  localparam logic [12:0] BPS_FOUR = 13'd4;

  typedef enum logic {
    KIND_SAMPLE = 1'b0,
    KIND_HEADER = 1'b1
  } wpd_kind_t;

  typedef struct packed {
    wpd_kind_t   kind;
    logic [15:0] num_channels;
    logic [31:0] sample_rate;
    logic [12:0] bytes_per_sample;
    logic        format_error;
    logic [31:0] raw;
  } wpd_item_t;

endpackage
`default_nettype wire

>>> design/wpd_front.sv
// Front end: tracks the header offset, captures header fields and assembles samples.
`timescale 1ns / 1ps
`default_nettype none
module wpd_front (
  input  wire logic             clk,
  input  wire logic             rst_n,
  input  wire logic             in_valid,
  output      logic             in_ready,
  input  wire logic [7:0]       in_data_byte,
  input  wire logic             in_start_of_file,
  input  wire logic             q_full,
  output      logic             q_push,
  output      wpd_pkg::wpd_item_t q_item
);
  import wpd_pkg::*;
  `include "wav_pcm_stream_deinterleaver_unit_assert.svh"

  logic [5:0]  offset_r, offset_nxt;
  logic [15:0] chan_r, chan_nxt;
  logic [31:0] rate_r, rate_nxt;
  logic [15:0] bits_r, bits_nxt;
  logic [31:0] asm_r, asm_nxt;
  logic [1:0]  bis_r, bis_nxt;
  logic        err_r, err_nxt;

  logic        accept;
  logic [5:0]  off_cur;
  logic [1:0]  bis_cur;
  logic        err_cur;
  logic [12:0] width;
  logic        bad;
  logic [31:0] asm_word;

  assign in_ready = !q_full;
  assign accept   = in_valid && in_ready;
  assign off_cur  = in_start_of_file ? 6'd0 : offset_r;
  assign bis_cur  = in_start_of_file ? 2'd0 : bis_r;
  assign err_cur  = in_start_of_file ? 1'b0 : err_r;
  assign width    = bits_r[15:3];
  assign bad      = (bits_r[2:0] != 3'd0)
                 || !((width == BPS_ONE) || (width == BPS_TWO) || (width == BPS_FOUR))
                 || (chan_r == 16'd0);
  assign asm_word = ((bis_cur == 2'd0) ? 32'd0 : asm_r)
                  | ({24'd0, in_data_byte} << {bis_cur, 3'b000});

  always_comb begin
    offset_nxt = offset_r;
    chan_nxt   = chan_r;
    rate_nxt   = rate_r;
    bits_nxt   = bits_r;
    asm_nxt    = asm_r;
    bis_nxt    = bis_r;
    err_nxt    = err_r;
    q_push     = 1'b0;
    q_item.kind             = KIND_SAMPLE;
    q_item.num_channels     = chan_r;
    q_item.sample_rate      = rate_r;
    q_item.bytes_per_sample = width;
    q_item.format_error     = 1'b0;
    q_item.raw              = asm_word;
    if (accept) begin
      bis_nxt = bis_cur;
      err_nxt = err_cur;
      if (off_cur < HDR_LEN) begin
        offset_nxt = off_cur + 6'd1;
        case (off_cur)
          OFF_CHAN_LO: chan_nxt = {chan_r[15:8], in_data_byte};
          OFF_CHAN_HI: chan_nxt = {in_data_byte, chan_r[7:0]};
          OFF_RATE_B0: rate_nxt = {rate_r[31:8], in_data_byte};
          OFF_RATE_B1: rate_nxt = {rate_r[31:16], in_data_byte, rate_r[7:0]};
          OFF_RATE_B2: rate_nxt = {rate_r[31:24], in_data_byte, rate_r[15:0]};
          OFF_RATE_B3: rate_nxt = {in_data_byte, rate_r[23:0]};
          OFF_BITS_LO: bits_nxt = {bits_r[15:8], in_data_byte};
          OFF_BITS_HI: bits_nxt = {in_data_byte, bits_r[7:0]};
          default: ;
        endcase
        if (off_cur == HDR_LAST) begin
          err_nxt             = bad;
          q_push              = 1'b1;
          q_item.kind         = KIND_HEADER;
          q_item.format_error = bad;
          q_item.raw          = 32'd0;
        end
      end else if (!err_cur) begin
        asm_nxt = asm_word;
        if (({11'd0, bis_cur} + 13'd1) < width) begin
          bis_nxt = bis_cur + 2'd1;
        end else begin
          bis_nxt = 2'd0;
          q_push  = 1'b1;
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      offset_r <= 6'd0;
      chan_r   <= 16'd0;
      rate_r   <= 32'd0;
      bits_r   <= 16'd0;
      bis_r    <= 2'd0;
      err_r    <= 1'b0;
    end else begin
      offset_r <= offset_nxt;
      chan_r   <= chan_nxt;
      rate_r   <= rate_nxt;
      bits_r   <= bits_nxt;
      bis_r    <= bis_nxt;
      err_r    <= err_nxt;
    end
  end

  always_ff @(posedge clk) begin
    asm_r <= asm_nxt;
  end

  `WPD_ASSERT_ALWAYS(a_offset_sat, clk, rst_n, offset_r <= HDR_LEN, "header offset passed 44")
  `WPD_ASSERT_IMPL(a_push_accept, clk, rst_n, q_push, accept, "queue push without a transaction")

endmodule
`default_nettype wire

>>> design/wpd_queue.sv
// Two-entry queue between the front end and the output stage.
`timescale 1ns / 1ps
`default_nettype none
module wpd_queue (
  input  wire logic               clk,
  input  wire logic               rst_n,
  input  wire logic               push,
  input  wire wpd_pkg::wpd_item_t push_item,
  output      logic               full,
  input  wire logic               pop,
  output      logic               not_empty,
  output      wpd_pkg::wpd_item_t head_item
);
  import wpd_pkg::*;
  `include "wav_pcm_stream_deinterleaver_unit_assert.svh"

  wpd_item_t  slot_r [2];
  logic       wr_ptr_r, wr_ptr_nxt;
  logic       rd_ptr_r, rd_ptr_nxt;
  logic [1:0] cnt_r, cnt_nxt;

  assign full      = (cnt_r == 2'd2);
  assign not_empty = (cnt_r != 2'd0);
  assign head_item = slot_r[rd_ptr_r];

  always_comb begin
    wr_ptr_nxt = push ? !wr_ptr_r : wr_ptr_r;
    rd_ptr_nxt = pop ? !rd_ptr_r : rd_ptr_r;
    cnt_nxt    = cnt_r + {1'b0, push} - {1'b0, pop};
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_ptr_r <= 1'b0;
      rd_ptr_r <= 1'b0;
      cnt_r    <= 2'd0;
    end else begin
      wr_ptr_r <= wr_ptr_nxt;
      rd_ptr_r <= rd_ptr_nxt;
      cnt_r    <= cnt_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (push) begin
      slot_r[wr_ptr_r] <= push_item;
    end
  end

  `WPD_ASSERT_ALWAYS(a_cnt_bound, clk, rst_n, cnt_r <= 2'd2, "queue count out of range")
  `WPD_ASSERT_IMPL(a_no_overflow, clk, rst_n, push, !full, "push into a full queue")
  `WPD_ASSERT_IMPL(a_no_underflow, clk, rst_n, pop, not_empty, "pop from an empty queue")

endmodule
`default_nettype wire

>>> design/wpd_back.sv
// Output stage: decodes samples, tags channel and frame, and holds the result register.
`timescale 1ns / 1ps
`default_nettype none
module wpd_back #(
  parameter int FRAME_COUNT_BITS = 32
) (
  input  wire logic               clk,
  input  wire logic               rst_n,
  input  wire logic               q_not_empty,
  input  wire wpd_pkg::wpd_item_t q_head,
  output      logic               q_pop,
  output      logic               out_valid,
  input  wire logic               out_ready,
  output      logic               out_is_header_result,
  output      logic [15:0]        out_num_channels,
  output      logic [31:0]        out_sample_rate,
  output      logic [12:0]        out_bytes_per_sample,
  output      logic               out_format_error,
  output      logic [15:0]        out_channel,
  output      logic [31:0]        out_sample_index,
  output      logic signed [31:0] out_sample_value
);
  import wpd_pkg::*;
  `include "wav_pcm_stream_deinterleaver_unit_assert.svh"

  logic                        valid_r, valid_nxt;
  logic [15:0]                 ch_r, ch_nxt;
  logic [FRAME_COUNT_BITS-1:0] frame_r, frame_nxt;
  logic                        hdr_r;
  logic [15:0]                 nch_r;
  logic [31:0]                 rate_r;
  logic [12:0]                 bps_r;
  logic                        err_r;
  logic [15:0]                 och_r;
  logic [31:0]                 idx_r;
  logic [31:0]                 val_r;
  logic [31:0]                 value;
  logic                        wrap;

  assign q_pop = q_not_empty && (!valid_r || out_ready);
  assign wrap  = (({1'b0, ch_r} + 17'd1) >= {1'b0, q_head.num_channels});

  always_comb begin
    case (q_head.bytes_per_sample)
      BPS_ONE: value = {24'd0, q_head.raw[7:0]};
      BPS_TWO: value = {{16{q_head.raw[15]}}, q_head.raw[15:0]};
      default: value = q_head.raw;
    endcase
  end

  always_comb begin
    valid_nxt = valid_r;
    ch_nxt    = ch_r;
    frame_nxt = frame_r;
    if (out_valid && out_ready) begin
      valid_nxt = 1'b0;
    end
    if (q_pop) begin
      valid_nxt = 1'b1;
      if (q_head.kind == KIND_HEADER) begin
        ch_nxt    = 16'd0;
        frame_nxt = '0;
      end else if (wrap) begin
        ch_nxt    = 16'd0;
        frame_nxt = frame_r + 1'b1;
      end else begin
        ch_nxt = ch_r + 16'd1;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      valid_r <= 1'b0;
      ch_r    <= 16'd0;
      frame_r <= '0;
    end else begin
      valid_r <= valid_nxt;
      ch_r    <= ch_nxt;
      frame_r <= frame_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (q_pop) begin
      hdr_r  <= (q_head.kind == KIND_HEADER);
      nch_r  <= q_head.num_channels;
      rate_r <= q_head.sample_rate;
      bps_r  <= q_head.bytes_per_sample;
      err_r  <= q_head.format_error;
      if (q_head.kind == KIND_HEADER) begin
        och_r <= 16'd0;
        idx_r <= 32'd0;
        val_r <= 32'd0;
      end else begin
        och_r <= ch_r;
        idx_r <= 32'(frame_r);
        val_r <= value;
      end
    end
  end

  assign out_valid            = valid_r;
  assign out_is_header_result = hdr_r;
  assign out_num_channels     = nch_r;
  assign out_sample_rate      = rate_r;
  assign out_bytes_per_sample = bps_r;
  assign out_format_error     = err_r;
  assign out_channel          = och_r;
  assign out_sample_index     = idx_r;
  assign out_sample_value     = val_r;

  `WPD_ASSERT_IMPL(a_err_on_header, clk, rst_n, valid_r && !hdr_r, !err_r,
    "format error flagged on a sample result")
  `WPD_ASSERT_IMPL(a_chan_range, clk, rst_n, valid_r && !hdr_r, och_r < nch_r,
    "channel index not below channel count")

endmodule
`default_nettype wire

>>> design/wav_pcm_stream_deinterleaver_unit.sv
// Top level of the WAV PCM stream deinterleaver.
//
// The input channel takes one byte of a WAV file per transaction, in file
// order; in_start_of_file marks offset 0 of a new file. The first 44 bytes
// are a fixed header: channel count, sample rate and bits per sample are
// captured, and on the last header byte one header result is given. Later
// bytes are assembled into samples of 1, 2 or 4 bytes, and each sample
// result carries its channel index and frame number. A file with a format
// error gives no sample results.
// One byte is accepted per cycle while in_ready is high. A result is written
// into a two-entry queue between the byte parser and the output register and
// then moved into the output register, where out_valid rises. The queue lets
// the parser keep taking bytes while a result waits; when the receiver stalls
// and the queue fills, in_ready drops until the output register is taken.
// After reset all counters are zero and the next byte is taken as offset 0.
`timescale 1ns / 1ps
`default_nettype none
module wav_pcm_stream_deinterleaver_unit #(
  parameter int FRAME_COUNT_BITS = 32
) (
  input  wire logic               clk,
  input  wire logic               rst_n,
  input  wire logic               in_valid,
  output      logic               in_ready,
  input  wire logic [7:0]         in_data_byte,
  input  wire logic               in_start_of_file,
  output      logic               out_valid,
  input  wire logic               out_ready,
  output      logic               out_is_header_result,
  output      logic [15:0]        out_num_channels,
  output      logic [31:0]        out_sample_rate,
  output      logic [12:0]        out_bytes_per_sample,
  output      logic               out_format_error,
  output      logic [15:0]        out_channel,
  output      logic [31:0]        out_sample_index,
  output      logic signed [31:0] out_sample_value
);
  import wpd_pkg::*;

  logic      q_full;
  logic      q_push;
  logic      q_pop;
  logic      q_not_empty;
  wpd_item_t push_item;
  wpd_item_t head_item;

  wpd_front u_front (
    .clk              (clk),
    .rst_n            (rst_n),
    .in_valid         (in_valid),
    .in_ready         (in_ready),
    .in_data_byte     (in_data_byte),
    .in_start_of_file (in_start_of_file),
    .q_full           (q_full),
    .q_push           (q_push),
    .q_item           (push_item)
  );

  wpd_queue u_queue (
    .clk       (clk),
    .rst_n     (rst_n),
    .push      (q_push),
    .push_item (push_item),
    .full      (q_full),
    .pop       (q_pop),
    .not_empty (q_not_empty),
    .head_item (head_item)
  );

  wpd_back #(
    .FRAME_COUNT_BITS (FRAME_COUNT_BITS)
  ) u_back (
    .clk                  (clk),
    .rst_n                (rst_n),
    .q_not_empty          (q_not_empty),
    .q_head               (head_item),
    .q_pop                (q_pop),
    .out_valid            (out_valid),
    .out_ready            (out_ready),
    .out_is_header_result (out_is_header_result),
    .out_num_channels     (out_num_channels),
    .out_sample_rate      (out_sample_rate),
    .out_bytes_per_sample (out_bytes_per_sample),
    .out_format_error     (out_format_error),
    .out_channel          (out_channel),
    .out_sample_index     (out_sample_index),
    .out_sample_value     (out_sample_value)
  );

endmodule
`default_nettype wire

>>> verif/tb_top.sv
// Testbench for the WAV PCM stream deinterleaver: directed and random files checked by a predictor.
`timescale 1ns / 1ps
module tb_top;
  import wpd_pkg::*;

  localparam int unsigned RANDOM_ITEMS   = 500;
  localparam int unsigned HOLD_FILE      = 2;
  localparam int unsigned HOLD_CYCLES    = 300;
  localparam int unsigned WATCHDOG_LIMIT = 2000;
  localparam int unsigned DRAIN_CYCLES   = 20;

  typedef enum int {
    PAT_RANDOM,
    PAT_ZERO,
    PAT_ONES,
    PAT_MIN,
    PAT_MAX
  } data_pat_t;

  typedef struct {
    logic        sof;
    int unsigned hdr_bytes;
    logic [15:0] nch;
    logic [31:0] rate;
    logic [15:0] bits;
    int unsigned data_bytes;
    data_pat_t   pat;
    logic        typed;
    logic        ferr;
  } file_row_t;

  typedef struct {
    wpd_kind_t          kind;
    logic [15:0]        num_channels;
    logic [31:0]        sample_rate;
    logic [12:0]        bytes_per_sample;
    logic               format_error;
    logic [15:0]        channel;
    logic [31:0]        sample_index;
    logic signed [31:0] sample_value;
  } pcm_result_t;

  logic               clk;
  logic               rst_n;
  logic               in_valid;
  logic               in_ready;
  logic [7:0]         in_data_byte;
  logic               in_start_of_file;
  logic               out_valid;
  logic               out_ready;
  logic               out_is_header_result;
  logic [15:0]        out_num_channels;
  logic [31:0]        out_sample_rate;
  logic [12:0]        out_bytes_per_sample;
  logic               out_format_error;
  logic [15:0]        out_channel;
  logic [31:0]        out_sample_index;
  logic signed [31:0] out_sample_value;

  pcm_result_t pending_results[$];
  int          errors = 0;
  int unsigned fed_bytes = 0;
  int unsigned stall_cycles = 0;
  bit          calm = 1'b0;
  bit          noisy = 1'b0;
  bit          hold_req = 1'b0;

  logic [5:0]  trk_offset = '0;
  logic [15:0] trk_channels = '0;
  logic [31:0] trk_rate = '0;
  logic [15:0] trk_bits = '0;
  logic [31:0] trk_assembly = '0;
  logic [1:0]  trk_fill = '0;
  logic [15:0] trk_chan_idx = '0;
  logic [31:0] trk_frame = '0;
  logic        trk_error = 1'b0;

  file_row_t directed_files [17] = '{
    '{1'b0, 44, 16'd2,     32'd44100,     16'd16,     16, PAT_RANDOM, 1'b1, 1'b0},
    '{1'b1, 44, 16'd1,     32'd0,         16'd8,      6,  PAT_ZERO,   1'b1, 1'b0},
    '{1'b1, 44, 16'd1,     32'hFFFF_FFFF, 16'd8,      6,  PAT_ONES,   1'b1, 1'b0},
    '{1'b1, 44, 16'd2,     32'd48000,     16'd16,     8,  PAT_MIN,    1'b1, 1'b0},
    '{1'b1, 44, 16'd2,     32'd48000,     16'd16,     8,  PAT_MAX,    1'b1, 1'b0},
    '{1'b1, 44, 16'd3,     32'd96000,     16'd32,     24, PAT_MIN,    1'b1, 1'b0},
    '{1'b1, 44, 16'd3,     32'd96000,     16'd32,     24, PAT_MAX,    1'b1, 1'b0},
    '{1'b1, 44, 16'hFFFF,  32'd8000,      16'd8,      10, PAT_RANDOM, 1'b1, 1'b0},
    '{1'b1, 44, 16'd0,     32'd22050,     16'd16,     8,  PAT_RANDOM, 1'b1, 1'b1},
    '{1'b1, 44, 16'd2,     32'd22050,     16'd12,     6,  PAT_RANDOM, 1'b1, 1'b1},
    '{1'b1, 44, 16'd2,     32'd22050,     16'd24,     6,  PAT_RANDOM, 1'b1, 1'b1},
    '{1'b1, 44, 16'd2,     32'd22050,     16'd0,      6,  PAT_RANDOM, 1'b1, 1'b1},
    '{1'b1, 44, 16'd2,     32'd22050,     16'hFFF8,   6,  PAT_RANDOM, 1'b1, 1'b1},
    '{1'b1, 44, 16'd2,     32'd22050,     16'hFFFF,   6,  PAT_RANDOM, 1'b1, 1'b1},
    '{1'b1, 44, 16'd2,     32'd11025,     16'd32,     7,  PAT_RANDOM, 1'b1, 1'b0},
    '{1'b1, 30, 16'd5,     32'd11025,     16'd16,     0,  PAT_RANDOM, 1'b0, 1'b0},
    '{1'b1, 44, 16'd4,     32'd44100,     16'd16,     21, PAT_RANDOM, 1'b1, 1'b0}
  };

  wav_pcm_stream_deinterleaver_unit DUT (
    .clk                  (clk),
    .rst_n                (rst_n),
    .in_valid             (in_valid),
    .in_ready             (in_ready),
    .in_data_byte         (in_data_byte),
    .in_start_of_file     (in_start_of_file),
    .out_valid            (out_valid),
    .out_ready            (out_ready),
    .out_is_header_result (out_is_header_result),
    .out_num_channels     (out_num_channels),
    .out_sample_rate      (out_sample_rate),
    .out_bytes_per_sample (out_bytes_per_sample),
    .out_format_error     (out_format_error),
    .out_channel          (out_channel),
    .out_sample_index     (out_sample_index),
    .out_sample_value     (out_sample_value)
  );

  initial begin
    clk = 1'b0;
    forever #5 clk = ~clk;
  end

  function automatic bit decode_byte(input logic [7:0] b, input logic sof,
                                     output pcm_result_t r, output bit dropped);
    logic [12:0]        w;
    logic signed [31:0] v;
    bit                 got;
    got = 1'b0;
    dropped = 1'b0;
    r.kind = KIND_SAMPLE;
    r.num_channels = '0;
    r.sample_rate = '0;
    r.bytes_per_sample = '0;
    r.format_error = 1'b0;
    r.channel = '0;
    r.sample_index = '0;
    r.sample_value = '0;
    if (sof) begin
      trk_offset = '0;
      trk_assembly = '0;
      trk_fill = '0;
      trk_chan_idx = '0;
      trk_frame = '0;
      trk_error = 1'b0;
    end
    if (trk_offset < HDR_LEN) begin
      case (trk_offset)
        OFF_CHAN_LO: trk_channels[7:0] = b;
        OFF_CHAN_HI: trk_channels[15:8] = b;
        OFF_RATE_B0: trk_rate[7:0] = b;
        OFF_RATE_B1: trk_rate[15:8] = b;
        OFF_RATE_B2: trk_rate[23:16] = b;
        OFF_RATE_B3: trk_rate[31:24] = b;
        OFF_BITS_LO: trk_bits[7:0] = b;
        OFF_BITS_HI: trk_bits[15:8] = b;
        default: ;
      endcase
      if (trk_offset == HDR_LAST) begin
        w = trk_bits[15:3];
        trk_error = (trk_bits[2:0] != 3'd0)
                 || !(w == BPS_ONE || w == BPS_TWO || w == BPS_FOUR)
                 || (trk_channels == 16'd0);
        r.kind = KIND_HEADER;
        r.num_channels = trk_channels;
        r.sample_rate = trk_rate;
        r.bytes_per_sample = w;
        r.format_error = trk_error;
        got = 1'b1;
      end
      trk_offset = trk_offset + 6'd1;
    end else if (trk_error) begin
      dropped = 1'b1;
    end else begin
      w = trk_bits[15:3];
      if (trk_fill == 2'd0) trk_assembly = '0;
      trk_assembly[8*trk_fill +: 8] = b;
      if (13'(trk_fill) + 13'd1 < w) begin
        trk_fill = trk_fill + 2'd1;
      end else begin
        trk_fill = '0;
        case (w)
          BPS_ONE: v = {24'd0, trk_assembly[7:0]};
          BPS_TWO: v = {{16{trk_assembly[15]}}, trk_assembly[15:0]};
          default: v = trk_assembly;
        endcase
        r.num_channels = trk_channels;
        r.sample_rate = trk_rate;
        r.bytes_per_sample = w;
        r.channel = trk_chan_idx;
        r.sample_index = trk_frame;
        r.sample_value = v;
        got = 1'b1;
        if (17'(trk_chan_idx) + 17'd1 >= 17'(trk_channels)) begin
          trk_chan_idx = '0;
          trk_frame = trk_frame + 32'd1;
        end else begin
          trk_chan_idx = trk_chan_idx + 16'd1;
        end
      end
    end
    return got;
  endfunction

  task automatic send_byte(input logic [7:0] b, input logic sof, input bit typed,
                           input pcm_result_t typed_r);
    pcm_result_t r;
    bit          dropped;
    int unsigned gap;
    gap = 0;
    while (!calm && $urandom_range(99) < 27) gap++;
    if (gap != 0) begin
      in_valid = 1'b0;
      repeat (gap) @(negedge clk);
    end
    in_valid = 1'b1;
    in_data_byte = b;
    in_start_of_file = sof;
    do @(posedge clk); while (!in_ready);
    if (decode_byte(b, sof, r, dropped)) pending_results.push_back(typed ? typed_r : r);
    if (!dropped) fed_bytes++;
    @(negedge clk);
  endtask

  task automatic send_file(input file_row_t f);
    pcm_result_t hdr_r;
    logic [7:0]  b;
    logic        sof;
    int unsigned wb;
    int unsigned pos;
    hdr_r.kind = KIND_HEADER;
    hdr_r.num_channels = f.nch;
    hdr_r.sample_rate = f.rate;
    hdr_r.bytes_per_sample = f.bits[15:3];
    hdr_r.format_error = f.ferr;
    hdr_r.channel = '0;
    hdr_r.sample_index = '0;
    hdr_r.sample_value = '0;
    for (int off = 0; off < f.hdr_bytes; off++) begin
      case (off)
        OFF_CHAN_LO: b = f.nch[7:0];
        OFF_CHAN_HI: b = f.nch[15:8];
        OFF_RATE_B0: b = f.rate[7:0];
        OFF_RATE_B1: b = f.rate[15:8];
        OFF_RATE_B2: b = f.rate[23:16];
        OFF_RATE_B3: b = f.rate[31:24];
        OFF_BITS_LO: b = f.bits[7:0];
        OFF_BITS_HI: b = f.bits[15:8];
        default:     b = 8'($urandom);
      endcase
      send_byte(b, (off == 0) ? f.sof : 1'b0, f.typed && (off == HDR_LAST), hdr_r);
    end
    wb = f.bits[15:3];
    if (!(wb == 1 || wb == 2 || wb == 4)) wb = 1;
    for (int k = 0; k < f.data_bytes; k++) begin
      pos = k % wb;
      case (f.pat)
        PAT_ZERO: b = 8'h00;
        PAT_ONES: b = 8'hFF;
        PAT_MIN:  b = (pos == wb - 1) ? 8'h80 : 8'h00;
        PAT_MAX:  b = (pos == wb - 1) ? 8'h7F : 8'hFF;
        default:  b = 8'($urandom);
      endcase
      sof = noisy && ($urandom_range(299) == 0);
      send_byte(b, sof, 1'b0, hdr_r);
    end
  endtask

  function automatic file_row_t random_file(input int unsigned idx);
    file_row_t   f;
    int unsigned pick;
    f.sof = ($urandom_range(19) != 0);
    f.hdr_bytes = ($urandom_range(9) == 0) ? $urandom_range(43, 1) : 44;
    pick = $urandom_range(99);
    if (pick < 70)      f.nch = 16'($urandom_range(4, 1));
    else if (pick < 80) f.nch = 16'd0;
    else if (pick < 85) f.nch = 16'hFFFF;
    else                f.nch = 16'($urandom);
    f.rate = $urandom;
    pick = $urandom_range(99);
    if (pick < 28)      f.bits = 16'd8;
    else if (pick < 56) f.bits = 16'd16;
    else if (pick < 84) f.bits = 16'd32;
    else                f.bits = 16'($urandom);
    f.data_bytes = ($urandom_range(9) == 0) ? $urandom_range(120, 41) : $urandom_range(40, 0);
    f.pat = ($urandom_range(4) == 0) ? data_pat_t'($urandom_range(4)) : PAT_RANDOM;
    f.typed = 1'b0;
    f.ferr = 1'b0;
    if (idx == HOLD_FILE) begin
      f.sof = 1'b1;
      f.hdr_bytes = 44;
      f.nch = 16'd2;
      f.bits = 16'd8;
      f.data_bytes = 160;
    end
    return f;
  endfunction

  function automatic void check_field(input string name, input logic [31:0] want,
                                      input logic [31:0] got);
    if (want !== got) begin
      $display("%0t: %s mismatch: expected %0h, actual %0h", $time, name, want, got);
      errors++;
    end
  endfunction

  always @(posedge clk) begin : result_check
    pcm_result_t exp_r;
    if (rst_n && out_valid && out_ready) begin
      if (pending_results.size() == 0) begin
        $display("%0t: unexpected result: expected none, actual kind %0b channel %0h value %0h",
                 $time, out_is_header_result, out_channel, out_sample_value);
        errors++;
      end else begin
        exp_r = pending_results.pop_front();
        check_field("is_header_result", 32'(exp_r.kind), 32'(out_is_header_result));
        check_field("num_channels", 32'(exp_r.num_channels), 32'(out_num_channels));
        check_field("sample_rate", exp_r.sample_rate, out_sample_rate);
        check_field("bytes_per_sample", 32'(exp_r.bytes_per_sample), 32'(out_bytes_per_sample));
        check_field("format_error", 32'(exp_r.format_error), 32'(out_format_error));
        check_field("channel", 32'(exp_r.channel), 32'(out_channel));
        check_field("sample_index", exp_r.sample_index, out_sample_index);
        check_field("sample_value", exp_r.sample_value, out_sample_value);
      end
    end
  end

  always @(posedge clk) begin
    if ((in_valid && in_ready) || (out_valid && out_ready)) stall_cycles <= 0;
    else stall_cycles <= stall_cycles + 1;
    if (stall_cycles >= WATCHDOG_LIMIT) begin
      $display("Testbench completed WITH ERRORS");
      $finish;
    end
  end

  initial begin : receiver
    int unsigned held;
    out_ready = 1'b0;
    forever begin
      @(negedge clk);
      if (hold_req) begin
        out_ready = 1'b0;
        for (held = 0; held < HOLD_CYCLES; held++) @(negedge clk);
        hold_req = 1'b0;
      end
      out_ready = calm || ($urandom_range(99) >= 27);
    end
  end

  initial begin : stimulus
    int unsigned nfile;
    in_valid = 1'b0;
    in_data_byte = 8'h00;
    in_start_of_file = 1'b0;
    rst_n = 1'b0;
    repeat (11) @(posedge clk);
    @(negedge clk);
    rst_n = 1'b1;
    foreach (directed_files[i]) send_file(directed_files[i]);
    fed_bytes = 0;
    noisy = 1'b1;
    nfile = 0;
    while (fed_bytes < RANDOM_ITEMS) begin
      calm = (nfile >= 5 && nfile < 9);
      if (nfile == HOLD_FILE) hold_req = 1'b1;
      send_file(random_file(nfile));
      nfile++;
    end
    in_valid = 1'b0;
    calm = 1'b0;
    while (pending_results.size() != 0) @(posedge clk);
    repeat (DRAIN_CYCLES) @(posedge clk);
    if (errors == 0) begin
      $display("Testbench completed without errors");
    end else begin
      $display("Testbench completed WITH ERRORS");
    end
    $finish;
  end

endmodule

>>> files.f
+incdir+design
design/wpd_pkg.sv
design/wpd_front.sv
design/wpd_queue.sv
design/wpd_back.sv
design/wav_pcm_stream_deinterleaver_unit.sv
verif/tb_top.sv
